[hdl/mandelbrot_escape_pixel_packer_unit_macros.svh]
// assertion shorthands for the escape pixel packer
`ifndef MANDELBROT_ESCAPE_PIXEL_PACKER_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_PIXEL_PACKER_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define MEPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MEPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mepp_pkg.sv]
package mepp_pkg;

    // fixed-point format of the coordinates
    localparam int COORD_W         = 32;
    localparam int COORD_FRAC_BITS = 26;
    localparam int ITER_WIDTH      = 12;
    localparam int PROD_W          = 2 * COORD_W;
    // wide enough for a shifted square or cross term plus c
    localparam int WIDE_W          = PROD_W - COORD_FRAC_BITS + 3;

    // escape limit: |z|^2 > 4, in squared fixed point
    localparam logic [PROD_W-1:0] ESC_LIMIT = PROD_W'(4) << (2 * COORD_FRAC_BITS);

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_ITER   = 3'd0,
        REG_INF_ENABLE = 3'd1,
        REG_INF_COLOUR = 3'd2,
        REG_BIAS       = 3'd3,
        REG_DEPTH      = 3'd4
    } cfg_reg_t;

    // reset values of the registers
    localparam logic [ITER_WIDTH-1:0] MAX_ITER_RST   = ITER_WIDTH'(256);
    localparam logic                  INF_ENABLE_RST = 1'b1;
    localparam logic [7:0]            INF_COLOUR_RST = 8'd0;
    localparam logic [7:0]            BIAS_RST       = 8'd16;
    localparam logic [1:0]            DEPTH_RST      = 2'd3;

    // depth code for one whole byte per pixel
    localparam logic [1:0] DEPTH_8BPP = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_RE,
        ST_SQ_IM,
        ST_CROSS,
        ST_UPDATE,
        ST_PACK
    } state_t;

    // clamp a wide signed value to the coordinate range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [WIDE_W-1:0] v
    );
        logic [WIDE_W-COORD_W:0] top;
        top = v[WIDE_W-1:COORD_W-1];
        if ((top == '0) || (top == '1))
            return v[COORD_W-1:0];
        else if (v[WIDE_W-1])
            return {1'b1, {(COORD_W-1){1'b0}}};
        else
            return {1'b0, {(COORD_W-1){1'b1}}};
    endfunction

endpackage

[hdl/mepp_point_if.sv]
interface mepp_point_if import mepp_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_real;
    logic signed [COORD_W-1:0] point_imag;
    logic                      last_in_row;

    modport source (output valid, point_real, point_imag, last_in_row, input ready);
    modport sink   (input valid, point_real, point_imag, last_in_row, output ready);
endinterface

[hdl/mepp_byte_if.sv]
interface mepp_byte_if import mepp_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       row_end;

    modport source (output valid, packed_byte, row_end, input ready);
    modport sink   (input valid, packed_byte, row_end, output ready);
endinterface

[hdl/mepp_cfg_if.sv]
interface mepp_cfg_if import mepp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/mandelbrot_escape_pixel_packer_unit.sv]
// Escape-time Mandelbrot pixel packer. Each point c arriving on "point" is iterated as
// z = z*z + c from z = c on one shared 32x32 signed multiplier, so an iteration steps through
// square of the real part, square of the imaginary part, cross product and update in turn.
// A zero limit skips the iteration and goes straight to the pack step; the block takes no new
// point until the current one is packed, and a full byte that meets a still-waiting output
// byte holds the pack step until the receiver takes it.
// Colours pack MSB-first into bytes at 1, 2, 4 or 8 bits per pixel and a byte leaves
// on "pixel_byte" when full or at the end of a row. The output byte is registered, so a
// waiting byte does not stop the next point from being taken. Registers are written through
// "cfg" (always ready) and should only change while the block is idle.
`include "mandelbrot_escape_pixel_packer_unit_macros.svh"

module mandelbrot_escape_pixel_packer_unit import mepp_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    mepp_point_if.sink   point,
    mepp_byte_if.source  pixel_byte,
    mepp_cfg_if.sink     cfg
);

    // configuration registers
    logic [ITER_WIDTH-1:0] max_iter_reg;
    logic                  inf_enable_reg;
    logic [7:0]            inf_colour_reg;
    logic [7:0]            bias_reg;
    logic [1:0]            depth_reg;

    // sequencer
    state_t state_reg, state_next;

    // iteration datapath
    logic signed [COORD_W-1:0] c_re_reg, c_re_next;
    logic signed [COORD_W-1:0] c_im_reg, c_im_next;
    logic                      last_reg, last_next;
    logic signed [COORD_W-1:0] z_re_reg, z_re_next;
    logic signed [COORD_W-1:0] z_im_reg, z_im_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [PROD_W-1:0]  xx_reg, xx_next;
    logic signed [WIDE_W-1:0]  re_sum_reg, re_sum_next;
    logic [ITER_WIDTH-1:0]     iter_reg, iter_next;
    logic                      check_reg, check_next;
    logic                      escaped_reg, escaped_next;

    // packer
    logic [7:0] acc_reg, acc_next;
    logic [2:0] slot_reg, slot_next;

    // output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_row_end_reg, out_row_end_next;

    // shared multiplier operands
    logic signed [COORD_W-1:0] mul_a, mul_b;

    // handshakes
    logic point_xfer;
    logic out_xfer;

    // escape test and loop exits
    logic [PROD_W-1:0]     mag_sum;
    logic                  escape_now;
    logic [ITER_WIDTH-1:0] iter_inc;
    logic                  limit_hit;

    // packing
    logic [3:0] bpp;
    logic [3:0] dots;
    logic [2:0] slot_m;
    logic [3:0] slot_inc;
    logic [3:0] shift_amt;
    logic [7:0] colour;
    logic [7:0] pix_mask;
    logic [7:0] acc_or;
    logic       emit;
    logic       pack_go;
    logic       no_escape_inf;

    assign point.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    assign point_xfer = point.valid && point.ready;
    assign out_xfer   = out_valid_reg && pixel_byte.ready;

    assign pixel_byte.valid       = out_valid_reg;
    assign pixel_byte.packed_byte = out_byte_reg;
    assign pixel_byte.row_end     = out_row_end_reg;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg   <= MAX_ITER_RST;
            inf_enable_reg <= INF_ENABLE_RST;
            inf_colour_reg <= INF_COLOUR_RST;
            bias_reg       <= BIAS_RST;
            depth_reg      <= DEPTH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_MAX_ITER:   max_iter_reg   <= ITER_WIDTH'(cfg.data);
                REG_INF_ENABLE: inf_enable_reg <= cfg.data[0];
                REG_INF_COLOUR: inf_colour_reg <= cfg.data[7:0];
                REG_BIAS:       bias_reg       <= cfg.data[7:0];
                REG_DEPTH:      depth_reg      <= cfg.data[1:0];
                default:        ;
            endcase
        end
    end

    // escape test on the squares of the latest z: xx held, yy just out of the multiplier
    assign mag_sum    = $unsigned(xx_reg) + $unsigned(prod_reg);
    assign escape_now = check_reg && (mag_sum > ESC_LIMIT);
    assign iter_inc   = iter_reg + ITER_WIDTH'(1);
    assign limit_hit  = check_reg && (iter_inc == max_iter_reg);

    // packing arithmetic: slot wraps to the current depth, fields fill from the MSB
    assign bpp           = 4'd1 << depth_reg;
    assign dots          = 4'd8 >> depth_reg;
    assign slot_m        = slot_reg & 3'(dots - 4'd1);
    assign slot_inc      = {1'b0, slot_m} + 4'd1;
    assign shift_amt     = 4'd8 - (slot_inc << depth_reg);
    assign pix_mask      = 8'((9'd1 << bpp) - 9'd1);
    assign no_escape_inf = !escaped_reg && inf_enable_reg;

    always_comb
    begin
        if (no_escape_inf)
            colour = inf_colour_reg;
        else if (depth_reg == DEPTH_8BPP)
            colour = 8'(iter_reg) + bias_reg;
        else
            colour = 8'(iter_reg);
    end

    assign acc_or  = acc_reg | ((colour & pix_mask) << shift_amt);
    assign emit    = (slot_inc >= dots) || last_reg;
    // a full byte waits for the output register to free up
    assign pack_go = !emit || !out_valid_reg || pixel_byte.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_xfer)
                    state_next = (max_iter_reg == '0) ? ST_PACK : ST_SQ_RE;
            end
            ST_SQ_RE:  state_next = ST_SQ_IM;
            ST_SQ_IM:  state_next = ST_CROSS;
            ST_CROSS:  state_next = (escape_now || limit_hit) ? ST_PACK : ST_UPDATE;
            ST_UPDATE: state_next = ST_SQ_RE;
            ST_PACK:
            begin
                if (pack_go)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs per state
    always_comb
    begin
        c_re_next        = c_re_reg;
        c_im_next        = c_im_reg;
        last_next        = last_reg;
        z_re_next        = z_re_reg;
        z_im_next        = z_im_reg;
        xx_next          = xx_reg;
        re_sum_next      = re_sum_reg;
        iter_next        = iter_reg;
        check_next       = check_reg;
        escaped_next     = escaped_reg;
        acc_next         = acc_reg;
        slot_next        = slot_reg;
        out_valid_next   = out_valid_reg && !out_xfer;
        out_byte_next    = out_byte_reg;
        out_row_end_next = out_row_end_reg;
        mul_a            = z_re_reg;
        mul_b            = z_re_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (point_xfer)
                begin
                    c_re_next    = point.point_real;
                    c_im_next    = point.point_imag;
                    last_next    = point.last_in_row;
                    z_re_next    = point.point_real;
                    z_im_next    = point.point_imag;
                    iter_next    = '0;
                    check_next   = 1'b0;
                    escaped_next = 1'b0;
                end
            end
            ST_SQ_RE:
            begin
                mul_a = z_re_reg;
                mul_b = z_re_reg;
            end
            ST_SQ_IM:
            begin
                xx_next = prod_reg;
                mul_a   = z_im_reg;
                mul_b   = z_im_reg;
            end
            ST_CROSS:
            begin
                mul_a       = z_re_reg;
                mul_b       = z_im_reg;
                // floor shifts: x^2 - y^2 + c_re
                re_sum_next = WIDE_W'(xx_reg >>> COORD_FRAC_BITS)
                            - WIDE_W'(prod_reg >>> COORD_FRAC_BITS)
                            + WIDE_W'(c_re_reg);
                if (escape_now)
                    escaped_next = 1'b1;
                else if (check_reg)
                    iter_next = iter_inc;
            end
            ST_UPDATE:
            begin
                // doubled cross term is the product shifted one place less
                z_re_next  = sat_coord(re_sum_reg);
                z_im_next  = sat_coord(WIDE_W'(prod_reg >>> (COORD_FRAC_BITS - 1))
                                       + WIDE_W'(c_im_reg));
                check_next = 1'b1;
            end
            ST_PACK:
            begin
                if (pack_go)
                begin
                    if (emit)
                    begin
                        out_valid_next   = 1'b1;
                        out_byte_next    = acc_or;
                        out_row_end_next = last_reg;
                        acc_next         = '0;
                        slot_next        = '0;
                    end
                    else
                    begin
                        acc_next  = acc_or;
                        slot_next = slot_inc[2:0];
                    end
                end
            end
            default: ;
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            check_reg     <= 1'b0;
            escaped_reg   <= 1'b0;
            iter_reg      <= '0;
            acc_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            z_re_reg      <= '0;
            z_im_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            check_reg     <= check_next;
            escaped_reg   <= escaped_next;
            iter_reg      <= iter_next;
            acc_reg       <= acc_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
            z_re_reg      <= z_re_next;
            z_im_reg      <= z_im_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        c_re_reg        <= c_re_next;
        c_im_reg        <= c_im_next;
        last_reg        <= last_next;
        prod_reg        <= prod_next;
        xx_reg          <= xx_next;
        re_sum_reg      <= re_sum_next;
        out_byte_reg    <= out_byte_next;
        out_row_end_reg <= out_row_end_next;
    end

    // the count never passes the limit while a point is in flight
    `MEPP_ASSERT_NOW(a_iter_in_range, (state_reg != ST_IDLE), (iter_reg <= max_iter_reg), "iteration count beyond limit")
    // a byte leaving the packer restarts the slot position
    `MEPP_ASSERT_NEXT(a_slot_clear, (state_reg == ST_PACK && pack_go && emit), (slot_reg == 3'd0 && acc_reg == 8'd0 && out_valid_reg), "packer not cleared after byte")
    // output bytes are only raised by the pack step
    `MEPP_ASSERT_NOW(a_out_source, $rose(out_valid_reg), ($past(state_reg) == ST_PACK), "output byte raised outside packing")

endmodule

[verif/mepp_pixel_byte_monitor.sv]
`timescale 1ns / 100ps

module mepp_pixel_byte_monitor import mepp_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    mepp_point_if point,
    mepp_byte_if  pixel_byte,
    mepp_cfg_if   cfg,
    input  logic  run_done,
    output int    fail_count,
    output int    bytes_pending,
    output int    bytes_checked
);

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       row_end;
    } byte_item_t;

    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam logic [64:0] ESCAPE_BOUND = 65'd4 << (2 * COORD_FRAC_BITS);

    // register copies
    logic [ITER_WIDTH-1:0] max_iter_q;
    logic                  inf_en_q;
    logic [7:0]            inf_col_q;
    logic [7:0]            bias_q;
    logic [1:0]            depth_q;

    // packer state
    logic [7:0] acc_q;
    int         slot_q;

    byte_item_t awaited_bytes[$];
    int         errors;
    int         checked;
    bit         leftovers_done;

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX;
        if (v < COORD_MIN)
            return COORD_MIN;
        return v;
    endfunction

    // z = z*z + c from z = c, floor rounding, saturated components
    function automatic void escape_orbit(
        input  logic signed [COORD_W-1:0] c_re,
        input  logic signed [COORD_W-1:0] c_im,
        input  logic [ITER_WIDTH-1:0]     limit_n,
        output int                        count,
        output logic                      escaped
    );
        longint      zr;
        longint      zi;
        longint      xx;
        longint      yy;
        longint      xy;
        logic [64:0] mag;
        zr = c_re;
        zi = c_im;
        count = 0;
        escaped = 1'b0;
        while (count < int'(limit_n) && !escaped) begin
            xx = zr * zr;
            yy = zi * zi;
            xy = zr * zi;
            zr = clamp_coord((xx >>> COORD_FRAC_BITS) - (yy >>> COORD_FRAC_BITS) + c_re);
            zi = clamp_coord((xy >>> (COORD_FRAC_BITS - 1)) + c_im);
            mag = 65'(zr * zr) + 65'(zi * zi);
            if (mag > ESCAPE_BOUND)
                escaped = 1'b1;
            else
                count++;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        errors++;
    endtask

    task automatic pack_point(
        input logic signed [COORD_W-1:0] c_re,
        input logic signed [COORD_W-1:0] c_im,
        input logic                      last
    );
        int         count;
        int         bpp;
        int         dots;
        int         shift;
        logic       escaped;
        logic       use_inf;
        logic [7:0] pix;
        escape_orbit(c_re, c_im, max_iter_q, count, escaped);
        use_inf = !escaped && inf_en_q;
        bpp = 1 << depth_q;
        dots = 8 / bpp;
        if (depth_q == DEPTH_8BPP)
            pix = use_inf ? inf_col_q : 8'(count + int'(bias_q));
        else
            pix = (use_inf ? inf_col_q : 8'(count)) & 8'((1 << bpp) - 1);
        // a depth change mid-byte wraps the slot and keeps the bits
        slot_q = slot_q & (dots - 1);
        shift = 8 - bpp * (slot_q + 1);
        acc_q = acc_q | 8'(pix << shift);
        slot_q++;
        if (slot_q >= dots || last) begin
            awaited_bytes.push_back('{packed_byte: acc_q, row_end: last});
            acc_q = '0;
            slot_q = 0;
        end
    endtask

    task automatic compare_byte(input logic [7:0] got_byte, input logic got_end);
        byte_item_t want;
        checked++;
        if (awaited_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %h row_end %b", got_byte, got_end));
            return;
        end
        want = awaited_bytes.pop_front();
        if (got_byte !== want.packed_byte)
            report_mismatch($sformatf("byte %0d packed_byte got %h want %h",
                                      checked, got_byte, want.packed_byte));
        if (got_end !== want.row_end)
            report_mismatch($sformatf("byte %0d row_end got %b want %b",
                                      checked, got_end, want.row_end));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            max_iter_q = MAX_ITER_RST;
            inf_en_q = INF_ENABLE_RST;
            inf_col_q = INF_COLOUR_RST;
            bias_q = BIAS_RST;
            depth_q = DEPTH_RST;
            acc_q = '0;
            slot_q = 0;
            awaited_bytes.delete();
            errors = 0;
            checked = 0;
            leftovers_done = 1'b0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_MAX_ITER:   max_iter_q = cfg.data[ITER_WIDTH-1:0];
                    REG_INF_ENABLE: inf_en_q = cfg.data[0];
                    REG_INF_COLOUR: inf_col_q = cfg.data[7:0];
                    REG_BIAS:       bias_q = cfg.data[7:0];
                    REG_DEPTH:      depth_q = cfg.data[1:0];
                    default:        ;
                endcase
            end
            if (point.valid && point.ready)
                pack_point(point.point_real, point.point_imag, point.last_in_row);
            if (pixel_byte.valid && pixel_byte.ready)
                compare_byte(pixel_byte.packed_byte, pixel_byte.row_end);
            if (run_done && !leftovers_done) begin
                foreach (awaited_bytes[i])
                    report_mismatch($sformatf("byte %h row_end %b never arrived",
                                              awaited_bytes[i].packed_byte,
                                              awaited_bytes[i].row_end));
                leftovers_done = 1'b1;
            end
        end
        fail_count <= errors;
        bytes_pending <= awaited_bytes.size();
        bytes_checked <= checked;
    end

endmodule

[verif/mandelbrot_escape_pixel_packer_unit_test.sv]
`timescale 1ns / 100ps

module mandelbrot_escape_pixel_packer_unit_test import mepp_pkg::*;;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 9;
    localparam int MAX_GAP        = 8;
    localparam int HOLD_CYCLES    = 400;
    // several times the slowest pixel at the top iteration limit plus the stalls
    localparam int WATCHDOG_LIMIT = 70000;
    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_IDX_W-1:0] SPARE_REG_IDX = 3'd5;
    // 1.0 in the coordinate format
    localparam int ONE = 1 << COORD_FRAC_BITS;
    localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;

    logic clk;
    logic rst_n;
    logic run_done;

    int fail_count;
    int bytes_pending;
    int bytes_checked;
    int points_sent;
    int settings_used;

    // current limit, sets how long the block may still be busy
    logic [ITER_WIDTH-1:0] max_iter_now = MAX_ITER_RST;
    bit no_idle;
    bit hold_request;

    mepp_point_if point ();
    mepp_byte_if  pixel_byte ();
    mepp_cfg_if   cfg ();

    mandelbrot_escape_pixel_packer_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .point      (point),
        .pixel_byte (pixel_byte),
        .cfg        (cfg)
    );

    // prediction and comparison live beside the block
    mepp_pixel_byte_monitor u_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .point         (point),
        .pixel_byte    (pixel_byte),
        .cfg           (cfg),
        .run_done      (run_done),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending),
        .bytes_checked (bytes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // one point transfer, with a random gap in front unless idling is off
    task automatic send_point(
        input logic signed [COORD_W-1:0] re,
        input logic signed [COORD_W-1:0] im,
        input logic                      last
    );
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            point.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point.valid       <= 1'b1;
        point.point_real  <= re;
        point.point_imag  <= im;
        point.last_in_row <= last;
        do @(posedge clk); while (!point.ready);
        points_sent++;
    endtask

    // valid stays up across a burst of writes, the caller drops it
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
    endtask

    // unused upper data bits carry noise, the block must drop them
    task automatic apply_settings(
        input logic [ITER_WIDTH-1:0] max_iter,
        input logic                  inf_en,
        input logic [7:0]            inf_col,
        input logic [7:0]            bias,
        input logic [1:0]            depth
    );
        write_reg(REG_MAX_ITER, max_iter);
        write_reg(REG_INF_ENABLE, {11'($urandom), inf_en});
        write_reg(REG_INF_COLOUR, {4'($urandom), inf_col});
        write_reg(REG_BIAS, {4'($urandom), bias});
        write_reg(REG_DEPTH, {10'($urandom), depth});
        write_reg(SPARE_REG_IDX, 12'($urandom));
        cfg.valid <= 1'b0;
        max_iter_now = max_iter;
        settings_used++;
    endtask

    // wait for every awaited byte, then for a pixel that makes no byte
    task automatic settle();
        point.valid <= 1'b0;
        @(posedge clk);
        while (bytes_pending != 0) @(posedge clk);
        repeat (4 * int'(max_iter_now) + 20) @(posedge clk);
    endtask

    // mix of points deep in the set, near its rim, and anywhere in the range
    task automatic run_phase(
        input int count,
        input int pct_deep,
        input int pct_rim,
        input bit carry_row
    );
        logic signed [COORD_W-1:0] re;
        logic signed [COORD_W-1:0] im;
        logic                      last;
        int                        pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < pct_deep)
            begin
                // square inside radius 0.25 of the origin, never escapes
                re = $urandom_range(0, 22000000) - 11000000;
                im = $urandom_range(0, 22000000) - 11000000;
            end
            else if (pick < pct_deep + pct_rim)
            begin
                // real -2 .. 0.5, imaginary -1.25 .. 1.25
                re = $urandom_range(0, 5 * ONE / 2) - 2 * ONE;
                im = $urandom_range(0, 5 * ONE / 2) - 5 * ONE / 4;
            end
            else
            begin
                re = $urandom();
                im = $urandom();
            end
            last = ($urandom_range(0, 5) == 0);
            // a carried row leaves a part byte across the next register change
            if (k == count - 1 && !carry_row)
                last = 1'b1;
            send_point(re, im, last);
        end
        settle();
    endtask

    // receiver: random ready gaps, plus one long hold-off on request
    initial
    begin
        int gap;
        pixel_byte.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                pixel_byte.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (gap > 0)
            begin
                pixel_byte.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pixel_byte.ready <= 1'b1;
            do @(posedge clk); while (!pixel_byte.valid);
        end
    end

    // watchdog: too long without any transfer on any channel
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((point.valid && point.ready) || (pixel_byte.valid && pixel_byte.ready)
                || (cfg.valid && cfg.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        rst_n             <= 1'b0;
        run_done          <= 1'b0;
        point.valid       <= 1'b0;
        point.point_real  <= '0;
        point.point_imag  <= '0;
        point.last_in_row <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= '0;
        cfg.data          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed points under the reset settings, one byte per pixel
        send_point(0, 0, 1'b0);                 // origin, never escapes
        send_point(C_MAX, C_MAX, 1'b1);         // square saturates both ways
        send_point(C_MIN, C_MIN, 1'b0);
        send_point(C_MIN, C_MAX, 1'b1);
        send_point(C_MAX, 0, 1'b0);
        send_point(C_MIN, 0, 1'b0);
        send_point(-2 * ONE, 0, 1'b1);          // |z|^2 sits exactly on 4
        send_point(0, ONE, 1'b0);               // cycles through -1+i and -i
        send_point(ONE / 4, 0, 1'b0);           // cusp, creeps towards 0.5
        send_point(2 * ONE, 0, 1'b1);           // gone at the first step
        send_point(-1, -1, 1'b0);               // smallest negative coordinates
        send_point(1, 1, 1'b0);
        send_point(3 * ONE / 10, 0, 1'b1);      // leaves after a while
        send_point(-3 * ONE / 4, ONE / 10, 1'b0);
        send_point(0, -2 * ONE, 1'b0);
        send_point(-ONE, 0, 1'b1);              // period two orbit
        send_point(ONE / 2, ONE / 2, 1'b1);
        settle();

        // depth change with a part byte held: 1 bpp then 4 bpp
        write_reg(REG_DEPTH, 12'd0);
        cfg.valid <= 1'b0;
        send_point(0, 0, 1'b0);
        send_point(2 * ONE, 0, 1'b0);
        send_point(0, 0, 1'b0);
        settle();
        write_reg(REG_DEPTH, 12'd2);
        cfg.valid <= 1'b0;
        send_point(3 * ONE / 10, 0, 1'b0);
        send_point(0, ONE / 2, 1'b1);
        settle();

        // zero iteration limit: nothing runs, every point counts as inside
        apply_settings(12'd0, 1'b1, 8'hA5, 8'hFF, DEPTH_8BPP);
        run_phase(20, 30, 30, 1'b0);
        apply_settings(12'd0, 1'b0, 8'h00, 8'h00, 2'd0);
        run_phase(24, 30, 30, 1'b1);

        // top iteration limit, only a few slow points
        apply_settings(12'hFFF, 1'b1, 8'hFF, 8'h00, 2'd2);
        run_phase(10, 10, 10, 1'b0);
        apply_settings(12'hFFF, 1'b0, 8'h5A, 8'h80, DEPTH_8BPP);
        run_phase(10, 10, 10, 1'b0);
        apply_settings(12'd1, 1'b0, 8'h3C, 8'h7E, 2'd1);
        run_phase(40, 30, 40, 1'b1);

        // random settings, every depth in turn
        for (int ph = 0; ph < 11; ph++)
        begin
            apply_settings(12'($urandom_range(1, 48)), 1'($urandom), 8'($urandom),
                           8'($urandom), 2'(ph % 4));
            no_idle = (ph == 3 || ph == 7);
            // long receiver stall while points keep coming at 8 bpp
            if (ph == 3)
                hold_request = 1'b1;
            run_phase(80, 20, 40, 1'($urandom));
            no_idle = 1'b0;
        end

        run_done <= 1'b1;
        repeat (3) @(posedge clk);
        $display("covered %0d points and %0d checked bytes over %0d register settings",
                 points_sent, bytes_checked, settings_used);
        $display("depths 1 to 8 bpp, limits 0 to 4095, saturation, part bytes, one long stall");
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[mandelbrot_escape_pixel_packer_unit.f]
+incdir+hdl
hdl/mepp_pkg.sv
hdl/mepp_point_if.sv
hdl/mepp_byte_if.sv
hdl/mepp_cfg_if.sv
hdl/mandelbrot_escape_pixel_packer_unit.sv
verif/mepp_pixel_byte_monitor.sv
verif/mandelbrot_escape_pixel_packer_unit_test.sv
